>>> sv/mcur_pkg.sv
`default_nettype none

package mcur_pkg;

  // Menu table size assumed when the top level is not told otherwise.
  localparam int MAX_ENTRIES_DEF = 16;

  // Field widths.
  localparam int CNT_W   = 5;   // entry_count; also the search index width
  localparam int POS_W   = 4;   // cursor position
  localparam int MASK_W  = 16;  // entries at or past this index never select
  localparam int DLY_W   = 10;  // delays, timers and elapsed time
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT       = 3'd0,
    REG_WRAP_ENABLE       = 3'd1,
    REG_VERTICAL_LAYOUT   = 3'd2,
    REG_DEFAULT_SELECTION = 3'd3,
    REG_SELECTABLE_MASK   = 3'd4,
    REG_FIRST_DELAY       = 3'd5,
    REG_REPEAT_DELAY      = 3'd6
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]  ENTRY_COUNT_RST       = 5'd16;
  localparam logic              WRAP_ENABLE_RST       = 1'b0;
  localparam logic              VERTICAL_LAYOUT_RST   = 1'b1;
  localparam logic [POS_W-1:0]  DEFAULT_SELECTION_RST = 4'd0;
  localparam logic [MASK_W-1:0] SELECTABLE_MASK_RST   = 16'hFFFF;
  localparam logic [DLY_W-1:0]  FIRST_DELAY_RST       = 10'd600;
  localparam logic [DLY_W-1:0]  REPEAT_DELAY_RST      = 10'd50;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ADVANCE = 2'd1,
    EV_CANCEL  = 2'd2,
    EV_MOVED   = 2'd3
  } event_e;

endpackage

`default_nettype wire

>>> sv/mcur_tick_if.sv
`default_nettype none

interface mcur_tick_if;
  logic       valid;
  logic       ready;
  logic       confirm_pressed;
  logic       cancel_pressed;
  logic       up_held;
  logic       down_held;
  logic       left_held;
  logic       right_held;
  logic [9:0] elapsed_ms;

  modport source (
    output valid, confirm_pressed, cancel_pressed, up_held, down_held,
           left_held, right_held, elapsed_ms,
    input  ready
  );

  modport sink (
    input  valid, confirm_pressed, cancel_pressed, up_held, down_held,
           left_held, right_held, elapsed_ms,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/mcur_result_if.sv
`default_nettype none

interface mcur_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic [3:0] cursor_now;
  logic [3:0] cursor_before;

  modport source (
    output valid, event_code, cursor_now, cursor_before,
    input  ready
  );

  modport sink (
    input  valid, event_code, cursor_now, cursor_before,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/menu_cursor_with_key_repeat.sv
// Channel   Dir  Modport  Payload
// tick_i    in   sink     confirm/cancel presses, four held keys, elapsed_ms
// result_o  out  source   event_code, cursor_now, cursor_before
// cfg_*     in   -        write enable, register index, write data
//
// A tick for confirm, cancel or no fire goes from idle to the output state. A fire
// adds a search that examines one candidate at a time, the one that ends it
// included: at most the larger of the effective entry count and cursor plus one
// (a downward search from at or past the count). With wrap enabled, cursor mod
// count goes first, one subtraction at a time until the borrow shows; both
// run on the one shared 6-bit adder. A new tick is taken only in idle, while
// the previous result may still sit in the output register.
// Reset loads the cursor with the default selection and idles both timers;
// a stalled result holds until taken and the sequencer waits for the slot.
`default_nettype none

module menu_cursor_with_key_repeat #(
  parameter int MAX_ENTRIES = mcur_pkg::MAX_ENTRIES_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [mcur_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [mcur_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  mcur_tick_if.sink                           tick_i,
  mcur_result_if.source                       result_o
);

  localparam int CW = mcur_pkg::CNT_W;
  localparam int PW = mcur_pkg::POS_W;
  localparam int DW = mcur_pkg::DLY_W;

  // Clamp for the effective entry count; the count register tops out at 31.
  localparam logic [CW-1:0] CountCap =
    (MAX_ENTRIES > (2**CW - 1)) ? {CW{1'b1}} : CW'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_SEARCH,
    ST_OUT
  } state_e;

  // Configuration registers
  logic [CW-1:0]               entry_count_q;
  logic                        wrap_q;
  logic                        vertical_q;
  logic [mcur_pkg::MASK_W-1:0] mask_q;
  logic [DW-1:0]               first_dly_q;
  logic [DW-1:0]               repeat_dly_q;

  // Sequencer and state
  state_e            state_q;
  logic [PW-1:0]     cursor_q;
  logic [PW-1:0]     before_q;
  logic [DW-1:0]     prev_tmr_q;
  logic [DW-1:0]     next_tmr_q;
  logic [CW-1:0]     sel_q;
  logic [CW-1:0]     step_q;
  logic              dir_up_q;
  mcur_pkg::event_e  code_q;

  // Output register
  logic              out_valid_q;
  mcur_pkg::event_e  out_code_q;
  logic [PW-1:0]     out_now_q;
  logic [PW-1:0]     out_before_q;

  // Advance one key's repeat timer; the top bit reports a fire.
  function automatic logic [DW:0] repeat_tick(input logic [DW-1:0] tmr,
                                              input logic          held,
                                              input logic [DW-1:0] dt,
                                              input logic [DW-1:0] first_dly,
                                              input logic [DW-1:0] rep_dly);
    logic [DW-1:0] left;
    left = (tmr > dt) ? (tmr - dt) : '0;
    if (tmr == '0) begin
      repeat_tick = held ? {1'b1, first_dly} : {1'b0, tmr};
    end else if (!held) begin
      repeat_tick = '0;
    end else if (left == '0) begin
      repeat_tick = {1'b1, rep_dly};
    end else begin
      repeat_tick = {1'b0, left};
    end
  endfunction

  //--------------------------------------------------------------------------
  // Configuration writes. default_selection only matters at reset, and reset
  // restores it to its reset value, so a write to it leaves nothing behind.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= mcur_pkg::ENTRY_COUNT_RST;
      wrap_q        <= mcur_pkg::WRAP_ENABLE_RST;
      vertical_q    <= mcur_pkg::VERTICAL_LAYOUT_RST;
      mask_q        <= mcur_pkg::SELECTABLE_MASK_RST;
      first_dly_q   <= mcur_pkg::FIRST_DELAY_RST;
      repeat_dly_q  <= mcur_pkg::REPEAT_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (mcur_pkg::cfg_reg_e'(cfg_index_i))
        mcur_pkg::REG_ENTRY_COUNT:     entry_count_q <= cfg_wdata_i[CW-1:0];
        mcur_pkg::REG_WRAP_ENABLE:     wrap_q        <= cfg_wdata_i[0];
        mcur_pkg::REG_VERTICAL_LAYOUT: vertical_q    <= cfg_wdata_i[0];
        mcur_pkg::REG_SELECTABLE_MASK: mask_q        <= cfg_wdata_i;
        mcur_pkg::REG_FIRST_DELAY:     first_dly_q   <= cfg_wdata_i[DW-1:0];
        mcur_pkg::REG_REPEAT_DELAY:    repeat_dly_q  <= cfg_wdata_i[DW-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Effective entry count: zero acts as one, clamp at the table size.
  //--------------------------------------------------------------------------
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_m1;

  always_comb begin
    if (entry_count_q == '0) begin
      cnt = CW'(1);
    end else if (entry_count_q > CountCap) begin
      cnt = CountCap;
    end else begin
      cnt = entry_count_q;
    end
    cnt_m1 = cnt - CW'(1);
  end

  //--------------------------------------------------------------------------
  // Key timers, evaluated on the accepted tick.
  //--------------------------------------------------------------------------
  logic          accept;
  logic          prev_held;
  logic          next_held;
  logic [DW:0]   prev_res;
  logic [DW:0]   next_res;

  assign tick_i.ready = (state_q == ST_IDLE);
  assign accept       = tick_i.valid && tick_i.ready;

  always_comb begin
    prev_held = vertical_q ? tick_i.up_held   : tick_i.left_held;
    next_held = vertical_q ? tick_i.down_held : tick_i.right_held;
    prev_res  = repeat_tick(prev_tmr_q, prev_held, tick_i.elapsed_ms,
                            first_dly_q, repeat_dly_q);
    next_res  = repeat_tick(next_tmr_q, next_held, tick_i.elapsed_ms,
                            first_dly_q, repeat_dly_q);
  end

  //--------------------------------------------------------------------------
  // Shared adder: subtracts the count while reducing the cursor, steps the
  // search index by one otherwise, and jumps to the last entry when a
  // downward wrapping search leaves entry zero.
  //--------------------------------------------------------------------------
  logic [CW:0]   addend;
  logic [CW:0]   sum;
  logic [CW-1:0] cand;
  logic          end_nowrap;
  logic          cand_ok;
  logic          hit_start;

  always_comb begin
    if (state_q == ST_MOD) begin
      addend = -{1'b0, cnt};
    end else if (dir_up_q) begin
      addend = (CW+1)'(1);
    end else if (wrap_q && sel_q == '0) begin
      addend = {1'b0, cnt_m1};
    end else begin
      addend = {(CW+1){1'b1}};
    end
    sum = {1'b0, sel_q} + addend;

    if (dir_up_q) begin
      cand       = (wrap_q && sum[CW-1:0] == cnt) ? '0 : sum[CW-1:0];
      end_nowrap = !wrap_q && (sum[CW-1:0] >= cnt);
    end else begin
      cand       = sum[CW-1:0];
      end_nowrap = !wrap_q && sum[CW];
    end

    cand_ok   = (cand < cnt) && (cand < CW'(mcur_pkg::MASK_W)) &&
                mask_q[cand[PW-1:0]];
    hit_start = wrap_q && (cand == {1'b0, cursor_q});
  end

  //--------------------------------------------------------------------------
  // Sequencer, state and output register.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cursor_q     <= mcur_pkg::DEFAULT_SELECTION_RST;
      before_q     <= '0;
      prev_tmr_q   <= '0;
      next_tmr_q   <= '0;
      sel_q        <= '0;
      step_q       <= '0;
      dir_up_q     <= 1'b0;
      code_q       <= mcur_pkg::EV_NONE;
      out_valid_q  <= 1'b0;
      out_code_q   <= mcur_pkg::EV_NONE;
      out_now_q    <= '0;
      out_before_q <= '0;
    end else begin
      // Drop the result once the sink takes it.
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            before_q <= cursor_q;
            sel_q    <= {1'b0, cursor_q};
            step_q   <= '0;
            code_q   <= mcur_pkg::EV_NONE;
            state_q  <= ST_OUT;
            if (tick_i.confirm_pressed) begin
              code_q <= mcur_pkg::EV_ADVANCE;
            end else if (tick_i.cancel_pressed) begin
              code_q <= mcur_pkg::EV_CANCEL;
            end else begin
              // Previous key has priority; its fire freezes the next timer.
              prev_tmr_q <= prev_res[DW-1:0];
              if (prev_res[DW]) begin
                dir_up_q <= 1'b0;
                state_q  <= wrap_q ? ST_MOD : ST_SEARCH;
              end else begin
                next_tmr_q <= next_res[DW-1:0];
                if (next_res[DW]) begin
                  dir_up_q <= 1'b1;
                  state_q  <= wrap_q ? ST_MOD : ST_SEARCH;
                end
              end
            end
          end
        end

        ST_MOD: begin
          // Reduce the start index below the count.
          if (!sum[CW]) begin
            sel_q <= sum[CW-1:0];
          end else begin
            state_q <= ST_SEARCH;
          end
        end

        ST_SEARCH: begin
          if (end_nowrap || hit_start) begin
            state_q <= ST_OUT;
          end else if (cand_ok) begin
            cursor_q <= cand[PW-1:0];
            code_q   <= mcur_pkg::EV_MOVED;
            state_q  <= ST_OUT;
          end else if (wrap_q && step_q == cnt_m1) begin
            state_q <= ST_OUT;
          end else begin
            sel_q  <= cand;
            step_q <= step_q + CW'(1);
          end
        end

        ST_OUT: begin
          // Hold until the output slot is free.
          if (!out_valid_q || result_o.ready) begin
            out_valid_q  <= 1'b1;
            out_code_q   <= code_q;
            out_now_q    <= cursor_q;
            out_before_q <= before_q;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.event_code    = out_code_q;
  assign result_o.cursor_now    = out_now_q;
  assign result_o.cursor_before = out_before_q;

endmodule

`default_nettype wire

>>> dv/mcur_checker.sv
`default_nettype none

module mcur_checker
  import mcur_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i,
  mcur_tick_if                 tick_mon,
  mcur_result_if               result_mon,
  output int                   fail_count_o
);

  typedef struct packed {
    event_e           ev;
    logic [POS_W-1:0] pos_now;
    logic [POS_W-1:0] pos_prior;
  } cursor_report_t;

  cursor_report_t pending_reports[$];
  int             mismatches;

  // Shadow of the configuration registers and of the block state.
  logic [CNT_W-1:0]  cnt_q;
  logic              wrap_q;
  logic              vert_q;
  logic [MASK_W-1:0] mask_q;
  logic [DLY_W-1:0]  first_q;
  logic [DLY_W-1:0]  rep_q;
  logic [POS_W-1:0]  cursor_q;
  logic [DLY_W-1:0]  prev_tmr_q;
  logic [DLY_W-1:0]  next_tmr_q;

  function automatic int live_entries();
    if (cnt_q == '0) return 1;
    if (int'(cnt_q) > MAX_ENTRIES_DEF) return MAX_ENTRIES_DEF;
    return int'(cnt_q);
  endfunction

  function automatic bit selectable(input int idx);
    if (idx >= live_entries() || idx >= MASK_W) return 1'b0;
    return mask_q[idx];
  endfunction

  // Step one key's repeat timer; return 1 when the key fires.
  function automatic bit key_fires(input logic [DLY_W-1:0] tmr, input logic held,
                                   input logic [DLY_W-1:0] dt,
                                   output logic [DLY_W-1:0] tmr_nx);
    tmr_nx = tmr;
    if (tmr == '0) begin
      if (held) begin
        tmr_nx = first_q;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!held) begin
      tmr_nx = '0;
      return 1'b0;
    end
    tmr_nx = (tmr > dt) ? tmr - dt : '0;
    if (tmr_nx == '0) begin
      tmr_nx = rep_q;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Move the cursor to the nearest selectable entry; return 1 on a move.
  function automatic bit seek_entry(input bit upward);
    int n;
    int sel;
    int cur;
    n   = live_entries();
    cur = int'(cursor_q);
    if (wrap_q) begin
      sel = cur % n;
      for (int k = 0; k < n; k++) begin
        sel = upward ? (sel + 1) % n : (sel + n - 1) % n;
        if (sel == cur) return 1'b0;
        if (selectable(sel)) begin
          cursor_q = sel[POS_W-1:0];
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (upward) begin
      for (sel = cur + 1; sel < n; sel++) begin
        if (selectable(sel)) begin
          cursor_q = sel[POS_W-1:0];
          return 1'b1;
        end
      end
    end else begin
      sel = cur;
      while (sel > 0) begin
        sel--;
        if (selectable(sel)) begin
          cursor_q = sel[POS_W-1:0];
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic cursor_report_t predict_menu_tick(
    input logic confirm, input logic cancel, input logic up, input logic down,
    input logic left, input logic right, input logic [DLY_W-1:0] dt);
    cursor_report_t   rep;
    logic             prev_held;
    logic             next_held;
    logic [DLY_W-1:0] tmr;
    rep.pos_prior = cursor_q;
    rep.ev        = EV_NONE;
    if (confirm) begin
      rep.ev = EV_ADVANCE;
    end else if (cancel) begin
      rep.ev = EV_CANCEL;
    end else begin
      prev_held = vert_q ? up : left;
      next_held = vert_q ? down : right;
      if (key_fires(prev_tmr_q, prev_held, dt, tmr)) begin
        prev_tmr_q = tmr;
        if (seek_entry(1'b0)) rep.ev = EV_MOVED;
      end else begin
        prev_tmr_q = tmr;
        if (key_fires(next_tmr_q, next_held, dt, tmr)) begin
          next_tmr_q = tmr;
          if (seek_entry(1'b1)) rep.ev = EV_MOVED;
        end else begin
          next_tmr_q = tmr;
        end
      end
    end
    rep.pos_now = cursor_q;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_report_t want;
    if (!rst_ni) begin
      cnt_q      = ENTRY_COUNT_RST;
      wrap_q     = WRAP_ENABLE_RST;
      vert_q     = VERTICAL_LAYOUT_RST;
      mask_q     = SELECTABLE_MASK_RST;
      first_q    = FIRST_DELAY_RST;
      rep_q      = REPEAT_DELAY_RST;
      cursor_q   = DEFAULT_SELECTION_RST;
      prev_tmr_q = '0;
      next_tmr_q = '0;
      mismatches = 0;
      pending_reports.delete();
      fail_count_o <= 0;
    end else begin
      // Compare first: a result never belongs to a tick taken at the same edge.
      if (result_mon.valid && result_mon.ready) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result: event_code %0d cursor_now %0d cursor_before %0d",
                 result_mon.event_code, result_mon.cursor_now, result_mon.cursor_before);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (result_mon.event_code !== want.ev) begin
            $error("event_code: expected %0d, actual %0d", want.ev, result_mon.event_code);
            mismatches++;
          end
          if (result_mon.cursor_now !== want.pos_now) begin
            $error("cursor_now: expected %0d, actual %0d", want.pos_now,
                   result_mon.cursor_now);
            mismatches++;
          end
          if (result_mon.cursor_before !== want.pos_prior) begin
            $error("cursor_before: expected %0d, actual %0d", want.pos_prior,
                   result_mon.cursor_before);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENTRY_COUNT:       cnt_q   = cfg_wdata_i[CNT_W-1:0];
          REG_WRAP_ENABLE:       wrap_q  = cfg_wdata_i[0];
          REG_VERTICAL_LAYOUT:   vert_q  = cfg_wdata_i[0];
          REG_DEFAULT_SELECTION: ; // only loaded into the cursor at reset
          REG_SELECTABLE_MASK:   mask_q  = cfg_wdata_i[MASK_W-1:0];
          REG_FIRST_DELAY:       first_q = cfg_wdata_i[DLY_W-1:0];
          REG_REPEAT_DELAY:      rep_q   = cfg_wdata_i[DLY_W-1:0];
          default: ;
        endcase
      end
      if (tick_mon.valid && tick_mon.ready) begin
        pending_reports.push_back(predict_menu_tick(
          tick_mon.confirm_pressed, tick_mon.cancel_pressed, tick_mon.up_held,
          tick_mon.down_held, tick_mon.left_held, tick_mon.right_held,
          tick_mon.elapsed_ms));
      end
      // Reports still owed count against the run once it has drained.
      fail_count_o <= mismatches + pending_reports.size();
    end
  end

endmodule

`default_nettype wire

>>> dv/menu_cursor_with_key_repeat_tb.sv
`default_nettype none

module menu_cursor_with_key_repeat_tb;
  import mcur_pkg::*;

  // Run shape: a directed warm-up, then random phases, each under its own setting.
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int LONG_STALL      = 400;
  localparam int TAIL_CYCLES     = 40;

  // One input tick as the sender sees it.
  typedef struct packed {
    logic             confirm;
    logic             cancel;
    logic             up;
    logic             down;
    logic             left;
    logic             right;
    logic [DLY_W-1:0] dt;
  } tick_t;

  // One full set of configuration register values.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              wrap;
    logic              vert;
    logic [POS_W-1:0]  home;
    logic [MASK_W-1:0] mask;
    logic [DLY_W-1:0]  first_dly;
    logic [DLY_W-1:0]  rep_dly;
  } menu_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    cycle_count = 0;
  int unsigned           ticks_sent = 0;
  int unsigned           results_taken = 0;
  logic                  quiet = 1'b0;          // no idling on either side
  logic                  long_stall_req = 1'b0; // ask the sink for one long hold-off
  menu_cfg_t             cur_cfg;

  mcur_tick_if   tick_bus ();
  mcur_result_if result_bus ();

  menu_cursor_with_key_repeat i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .tick_i      (tick_bus),
    .result_o    (result_bus)
  );

  mcur_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .tick_mon     (tick_bus),
    .result_mon   (result_bus),
    .fail_count_o (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: end the run if the block hangs somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic tick_t key_tick(input bit c, input bit x, input bit u, input bit d,
                                     input bit l, input bit r, input int dt);
    return '{c, x, u, d, l, r, 10'(dt)};
  endfunction

  // Drive one register write; the caller drops the write enable after a batch.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Write every register; call only while the block is idle.
  task automatic program_menu(input menu_cfg_t c);
    write_reg(REG_ENTRY_COUNT,       CFG_DATA_W'(c.count));
    write_reg(REG_WRAP_ENABLE,       CFG_DATA_W'(c.wrap));
    write_reg(REG_VERTICAL_LAYOUT,   CFG_DATA_W'(c.vert));
    write_reg(REG_DEFAULT_SELECTION, CFG_DATA_W'(c.home));
    write_reg(REG_SELECTABLE_MASK,   c.mask);
    write_reg(REG_FIRST_DELAY,       CFG_DATA_W'(c.first_dly));
    write_reg(REG_REPEAT_DELAY,      CFG_DATA_W'(c.rep_dly));
    cfg_we  <= 1'b0;
    cur_cfg  = c;
  endtask

  // Offer one tick, maybe after a random gap, and hold it until taken.
  // Valid stays high on return so that back-to-back ticks need no toggle.
  task automatic offer_tick(input tick_t t);
    if (!quiet && $urandom_range(99) < 9) begin
      tick_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    tick_bus.valid           <= 1'b1;
    tick_bus.confirm_pressed <= t.confirm;
    tick_bus.cancel_pressed  <= t.cancel;
    tick_bus.up_held         <= t.up;
    tick_bus.down_held       <= t.down;
    tick_bus.left_held       <= t.left;
    tick_bus.right_held      <= t.right;
    tick_bus.elapsed_ms      <= t.dt;
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Drop valid and hold until every outstanding transaction has returned.
  task automatic drain();
    tick_bus.valid <= 1'b0;
    while (results_taken != ticks_sent) @(posedge clk);
  endtask

  // Result sink: random stalls, one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    bit stall_done;
    stall_left = 0;
    stall_done = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) results_taken <= results_taken + 1;
      if (long_stall_req && !stall_done) begin
        stall_done = 1'b1;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin : stimulus
    menu_cfg_t   setting;
    tick_t       item;
    int          roll;
    int          pick;
    int          run_left;
    int          dt_cap;
    logic [3:0]  keys;   // {up, down, left, right}

    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_index                <= REG_ENTRY_COUNT;
    cfg_wdata                <= '0;
    tick_bus.valid           <= 1'b0;
    tick_bus.confirm_pressed <= 1'b0;
    tick_bus.cancel_pressed  <= 1'b0;
    tick_bus.up_held         <= 1'b0;
    tick_bus.down_held       <= 1'b0;
    tick_bus.left_held       <= 1'b0;
    tick_bus.right_held      <= 1'b0;
    tick_bus.elapsed_ms      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: vertical layout, no wrap, short delays. The cursor starts at 0;
    // the new default selection must not move it since no reset follows.
    program_menu('{5'd16, 1'b0, 1'b1, 4'd9, 16'hFFFF, 10'd3, 10'd2});
    offer_tick(key_tick(1, 1, 0, 0, 0, 0, 0));    // confirm beats cancel
    offer_tick(key_tick(0, 1, 1, 1, 1, 1, 1023)); // cancel, timers untouched
    offer_tick(key_tick(1, 0, 1, 0, 0, 0, 5));    // confirm with a key held
    offer_tick(key_tick(0, 0, 1, 0, 0, 0, 0));    // up at the top: fires, no move
    offer_tick(key_tick(0, 0, 0, 1, 0, 0, 1));    // release up, press down
    offer_tick(key_tick(0, 0, 0, 1, 0, 0, 1));    // held, still counting
    offer_tick(key_tick(0, 0, 0, 1, 0, 0, 1023)); // timer saturates at zero
    offer_tick(key_tick(0, 0, 0, 1, 0, 0, 2));    // repeat delay fires
    offer_tick(key_tick(0, 0, 1, 1, 0, 0, 1));    // up fires, down timer frozen
    offer_tick(key_tick(0, 0, 1, 1, 0, 0, 0));    // zero elapsed time
    offer_tick(key_tick(0, 0, 0, 0, 1, 1, 7));    // off-layout keys ignored
    drain();

    // Zero entry count, one selectable entry, zero delays, cursor past the count.
    program_menu('{5'd0, 1'b1, 1'b0, 4'd15, 16'h0001, 10'd0, 10'd0});
    offer_tick(key_tick(0, 0, 0, 0, 0, 1, 3));
    offer_tick(key_tick(0, 0, 0, 0, 1, 0, 0));    // search comes back to itself
    offer_tick(key_tick(0, 0, 0, 0, 1, 0, 0));    // zero delay fires every tick
    offer_tick(key_tick(0, 0, 0, 0, 0, 1, 9));
    drain();

    // Oversized entry count, wrap across both table ends, longest delays.
    program_menu('{5'd31, 1'b1, 1'b0, 4'd0, 16'h8001, 10'd1023, 10'd1023});
    offer_tick(key_tick(0, 0, 0, 0, 1, 0, 1023));
    offer_tick(key_tick(0, 0, 0, 0, 1, 0, 1022));
    offer_tick(key_tick(0, 0, 0, 0, 1, 0, 1));
    offer_tick(key_tick(0, 0, 0, 0, 0, 1, 0));
    offer_tick(key_tick(0, 0, 0, 0, 0, 1, 10'h2AA));
    drain();

    // Nothing selectable, no wrap, cursor past the entry count.
    program_menu('{5'd5, 1'b0, 1'b1, 4'd3, 16'h0000, 10'd1, 10'd1});
    offer_tick(key_tick(0, 0, 1, 0, 0, 0, 0));
    offer_tick(key_tick(0, 0, 0, 1, 0, 0, 10'h155));
    offer_tick(key_tick(0, 0, 0, 1, 0, 0, 1));
    drain();

    // Random phases: mostly held-key runs so the repeat timers get exercised,
    // with presses of confirm or cancel and fully random ticks mixed in.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      setting.count     = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
                                                   : 5'($urandom_range(1, 16));
      setting.wrap      = 1'($urandom_range(1));
      setting.vert      = 1'($urandom_range(1));
      setting.home      = 4'($urandom);
      setting.mask      = 16'($urandom);
      setting.first_dly = 10'($urandom_range(0, 60));
      setting.rep_dly   = 10'($urandom_range(0, 25));
      if (ph == 0) setting = '{5'd1, 1'b0, 1'b1, 4'd0, 16'hFFFF, 10'd1, 10'd1};
      if (ph == 1) setting = '{5'd16, 1'b1, 1'b0, 4'd15, 16'hFFFF, 10'd1023, 10'd1023};
      program_menu(setting);
      if (ph == 2) long_stall_req <= 1'b1;  // sink backs off, the block fills up
      quiet <= (ph == 4);                    // one long stretch without idling
      dt_cap   = (int'(cur_cfg.rep_dly) > 1018) ? 1023 : int'(cur_cfg.rep_dly) + 5;
      run_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        item = tick_t'($urandom);
        if (roll < 8) begin
          if (!item.confirm) item.cancel = 1'b1;
        end else if (roll >= 20) begin
          if (run_left == 0) begin
            pick = $urandom_range(9);
            if (pick < 7) begin
              if (cur_cfg.vert) keys = pick[0] ? 4'b1000 : 4'b0100;
              else              keys = pick[0] ? 4'b0010 : 4'b0001;
            end else if (pick == 7) begin
              keys = 4'($urandom);
            end else begin
              keys = 4'b0000;
            end
            run_left = $urandom_range(1, 14);
          end
          run_left--;
          item.confirm = 1'b0;
          item.cancel  = 1'b0;
          {item.up, item.down, item.left, item.right} = keys;
          item.dt = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                             : 10'($urandom_range(0, dt_cap));
        end
        offer_tick(item);
      end
      drain();
    end
    quiet <= 1'b0;

    // Let any late or spurious result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
